// ----- sv/pcbp_pkg.sv -----
// Shared types and constants for the prefix code byte packer.
package pcbp_pkg;

    localparam int SYMBOL_COUNT         = 256;
    localparam int SYM_W                = 8;
    localparam int LEN_W                = 6;
    localparam int CODE_W               = 32;
    localparam int BYTE_W               = 8;
    localparam int CMD_W                = 2;
    localparam int MAX_RESULTS          = 4;
    localparam int DEFAULT_MAX_CODE_LEN = 32;
    localparam int S_TDATA_W            = 48;
    localparam int ENTRY_W              = LEN_W + CODE_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_DATA   = 2'd1,
        CMD_FINISH = 2'd2
    } cmd_t;

endpackage

// ----- sv/pcbp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/prefix_code_byte_packer.sv -----
// Prefix code byte packer: top level with code table, bit accumulator and output buffer.
//
// Input stream (s_): tuser carries the command, tdata the symbol, code length and
// code bits. A load transfer writes one table entry (length saturated at the code
// length cap). A data transfer appends the symbol's code, MSB first, to the bit
// accumulator and emits every completed byte. A finish transfer emits the partial
// byte padded with zeros, if any, then a byte holding the pad-bit count with tlast.
// Output stream (m_): one packed byte per transfer, tlast on the pad-count byte.
//
// Path: the table read registers on the edge of the input transfer; the pack then
// registers the item's bytes into the output buffer, which drives the m_ stream.
// Throughput: one item per cycle while items yield at most one byte each and the
// receiver does not stall; otherwise an item yielding several bytes (up to four)
// holds the pack stage until the one-byte-per-cycle output buffer is down to its
// last byte. Loads and unused commands do not enter the pack stage.
//
// Reset clears the accumulator, the output buffer and the per-entry valid flags,
// so every table entry reads as length zero until loaded; no clearing pass.
// When the receiver stalls, the output buffer holds its bytes, the item waiting
// on the table read holds, and s_tready drops until the buffer drains.
module prefix_code_byte_packer
    #(
    parameter int MAX_CODE_LEN = pcbp_pkg::DEFAULT_MAX_CODE_LEN
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [7:0] symbol, [13:8] code_length, [45:14] code_bits, [47:46] zero
    input  logic [pcbp_pkg::S_TDATA_W-1:0]      s_tdata,
    // [1:0] cmd
    input  logic [pcbp_pkg::CMD_W-1:0]          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] out_byte
    output logic [pcbp_pkg::BYTE_W-1:0]         m_tdata,
    output logic                                m_tlast
);
    import pcbp_pkg::*;

    localparam int LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
    localparam int ACC_W   = CODE_W + BYTE_W - 1;
    localparam int AL_W    = ACC_W + 1;
    localparam int CNT_W   = $clog2(BYTE_W);
    localparam int TOT_W   = $clog2(ACC_W + 1);
    localparam int BUF_W   = $clog2(MAX_RESULTS + 1);

    logic [SYM_W-1:0]  in_sym;
    logic [LEN_W-1:0]  in_len;
    logic [CODE_W-1:0] in_code;
    cmd_t              in_cmd;
    logic              s_accept;
    logic [LEN_W-1:0]  len_sat;

    logic [ENTRY_W-1:0] ram_rdata;
    logic [LEN_W-1:0]   ram_len;
    logic [CODE_W-1:0]  ram_code;

    logic [SYMBOL_COUNT-1:0] vld_reg, vld_next;
    logic                    s1_valid_reg, s1_valid_next;
    cmd_t                    s1_cmd_reg, s1_cmd_next;
    logic                    s1_vld_reg, s1_vld_next;

    logic [BYTE_W-2:0] pend_bits_reg, pend_bits_next;
    logic [CNT_W-1:0]  pend_cnt_reg, pend_cnt_next;

    logic [BYTE_W-1:0] buf_byte_reg [MAX_RESULTS];
    logic [BYTE_W-1:0] buf_byte_next [MAX_RESULTS];
    logic              buf_last_reg [MAX_RESULTS];
    logic              buf_last_next [MAX_RESULTS];
    logic [BUF_W-1:0]  buf_cnt_reg, buf_cnt_next;

    logic              fire;
    logic              m_accept;

    logic [LEN_W-1:0]  len_eff;
    logic [CODE_W:0]   code_mask;
    logic [CODE_W-1:0] code_m;
    logic [ACC_W-1:0]  acc_val;
    logic [TOT_W-1:0]  total;
    logic [AL_W-1:0]   acc_al;
    logic [BYTE_W-1:0] rem_mask;
    logic [CNT_W-1:0]  pad;
    logic [BYTE_W-1:0] pad_byte;
    logic [BYTE_W-1:0] part_byte;

    logic [BYTE_W-1:0] new_byte [MAX_RESULTS];
    logic              new_last [MAX_RESULTS];
    logic [BUF_W-1:0]  new_cnt;
    logic [BYTE_W-2:0] new_bits;
    logic [CNT_W-1:0]  new_pcnt;

    assign in_sym   = s_tdata[SYM_W-1:0];
    assign in_len   = s_tdata[SYM_W +: LEN_W];
    assign in_code  = s_tdata[SYM_W+LEN_W +: CODE_W];
    assign in_cmd   = cmd_t'(s_tuser);
    assign s_accept = s_tvalid && s_tready;
    assign len_sat  = (in_len > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : in_len;

    pcbp_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(SYMBOL_COUNT)
    ) u_table (
        .aclk (aclk),
        .we   (s_accept && (in_cmd == CMD_LOAD)),
        .waddr(in_sym),
        .wdata({len_sat, in_code}),
        .re   (s_accept),
        .raddr(in_sym),
        .rdata(ram_rdata)
    );

    assign ram_len  = ram_rdata[CODE_W +: LEN_W];
    assign ram_code = ram_rdata[CODE_W-1:0];

    assign m_accept = m_tvalid && m_tready;
    assign fire     = s1_valid_reg &&
                      ((buf_cnt_reg == '0) ||
                       ((buf_cnt_reg == BUF_W'(1)) && m_tready));
    assign s_tready = !s1_valid_reg || fire;

    // Pack pending bits and looked-up code into whole bytes; on finish, flush and pad.
    always_comb begin
        len_eff   = s1_vld_reg ? ram_len : '0;
        code_mask = ({{CODE_W{1'b0}}, 1'b1} << len_eff) - 1'b1;
        code_m    = ram_code & code_mask[CODE_W-1:0];
        acc_val   = ({{(ACC_W-BYTE_W+1){1'b0}}, pend_bits_reg} << len_eff)
                    | {{(ACC_W-CODE_W){1'b0}}, code_m};
        total     = TOT_W'(pend_cnt_reg) + TOT_W'(len_eff);
        acc_al    = {1'b0, acc_val} << (TOT_W'(AL_W) - total);
        rem_mask  = (BYTE_W'(1) << total[CNT_W-1:0]) - 1'b1;
        pad       = CNT_W'(0) - pend_cnt_reg;
        pad_byte  = BYTE_W'(pad);
        part_byte = {1'b0, pend_bits_reg} << pad;

        for (int i = 0; i < MAX_RESULTS; i++) begin
            new_byte[i] = acc_al[AL_W-1-BYTE_W*i -: BYTE_W];
            new_last[i] = 1'b0;
        end
        new_cnt  = BUF_W'(total[TOT_W-1:CNT_W]);
        new_bits = acc_val[BYTE_W-2:0] & rem_mask[BYTE_W-2:0];
        new_pcnt = total[CNT_W-1:0];

        if (s1_cmd_reg == CMD_FINISH) begin
            new_bits = '0;
            new_pcnt = '0;
            if (pend_cnt_reg != '0) begin
                new_byte[0] = part_byte;
                new_byte[1] = pad_byte;
                new_last[1] = 1'b1;
                new_cnt     = BUF_W'(2);
            end else begin
                new_byte[0] = pad_byte;
                new_last[0] = 1'b1;
                new_cnt     = BUF_W'(1);
            end
        end
    end

    always_comb begin
        vld_next      = vld_reg;
        s1_valid_next = s1_valid_reg;
        s1_cmd_next   = s1_cmd_reg;
        s1_vld_next   = s1_vld_reg;
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        buf_cnt_next   = buf_cnt_reg;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            buf_byte_next[i] = buf_byte_reg[i];
            buf_last_next[i] = buf_last_reg[i];
        end

        if (s_accept && (in_cmd == CMD_LOAD)) begin
            vld_next[in_sym] = 1'b1;
        end

        if (s_tready) begin
            s1_valid_next = s_accept &&
                            ((in_cmd == CMD_DATA) || (in_cmd == CMD_FINISH));
            s1_cmd_next   = in_cmd;
            s1_vld_next   = vld_reg[in_sym];
        end

        if (fire) begin
            pend_bits_next = new_bits;
            pend_cnt_next  = new_pcnt;
            buf_cnt_next   = new_cnt;
            for (int i = 0; i < MAX_RESULTS; i++) begin
                buf_byte_next[i] = new_byte[i];
                buf_last_next[i] = new_last[i];
            end
        end else if (m_accept) begin
            // Advance the buffer by one byte.
            buf_cnt_next = buf_cnt_reg - 1'b1;
            for (int i = 0; i < MAX_RESULTS - 1; i++) begin
                buf_byte_next[i] = buf_byte_reg[i+1];
                buf_last_next[i] = buf_last_reg[i+1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
            buf_cnt_reg   <= '0;
        end else begin
            vld_reg       <= vld_next;
            s1_valid_reg  <= s1_valid_next;
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
            buf_cnt_reg   <= buf_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_cmd_reg <= s1_cmd_next;
        s1_vld_reg <= s1_vld_next;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            buf_byte_reg[i] <= buf_byte_next[i];
            buf_last_reg[i] <= buf_last_next[i];
        end
    end

    assign m_tvalid = (buf_cnt_reg != '0);
    assign m_tdata  = buf_byte_reg[0];
    assign m_tlast  = buf_last_reg[0];

endmodule
